// ===== design/srg_pkg.sv =====
// Shared types, constants and arithmetic helpers of the subtractive random generator.
// No dependencies; srg_ctrl, srg_datapath and the top level import this package.
package srg_pkg;

  localparam int TblLen = 55;
  localparam int IdxW = $clog2(TblLen);
  localparam int ValW = 30;
  localparam int SeedW = 32;
  localparam int NumPasses = 4;
  localparam int PassW = $clog2(NumPasses);

  localparam logic [ValW-1:0] Mod = 30'd1000000000;
  localparam logic [ValW-1:0] SeedBase = 30'd161803398;

  localparam logic [IdxW-1:0] FillStep = IdxW'(21);
  localparam logic [IdxW-1:0] FarStart = IdxW'(31);
  // Storage distance between an entry and its partner during the mixing passes.
  localparam logic [IdxW-1:0] MixOffset = IdxW'(31);
  // Position written by the last step of the initial fill.
  localparam logic [IdxW-1:0] FillLastPos = IdxW'((21 * (TblLen - 1)) % TblLen);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TblLen - 1);
  localparam logic [IdxW-1:0] TblLenIdx = IdxW'(TblLen);
  localparam logic [PassW-1:0] LastPass = PassW'(NumPasses - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // request accepted: capture the seed magnitude
    logic calc;        // form the first residue, reset counters and cursors
    logic fill;        // one step of the initial table fill
    logic mix;         // one read step of the mixing passes
    logic draw_rd;     // advance cursors and read both entries
    logic draw_wr;     // write back the difference and present the result
    logic did_reseed;  // this request reinitialised the table
  } srg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic mix_last;
  } srg_stat_t;

  // Difference of two residues, taken modulo 10^9.
  function automatic logic [ValW-1:0] sub_mod(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [ValW-1:0] diff;
    diff = a - b;
    if (a >= b) begin
      return diff;
    end else begin
      return diff + Mod;
    end
  endfunction

endpackage

// ===== design/srg_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module srg_ram #(
  parameter int Width = 30,
  parameter int Depth = 55,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wa_i,
  input  logic [Width-1:0] wd_i,
  input  logic [AddrW-1:0] ra_a_i,
  input  logic [AddrW-1:0] ra_b_i,
  output logic [Width-1:0] rd_a_o,
  output logic [Width-1:0] rd_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    rd_a_o <= mem_q[ra_a_i];
    rd_b_o <= mem_q[ra_b_i];
  end

endmodule

// ===== design/srg_ctrl.sv =====
// Sequencing state machine of the subtractive random generator.
// Depends on srg_pkg for the command and status types.
module srg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              seed_neg_i,
  input  srg_pkg::srg_stat_t stat_i,
  output srg_pkg::srg_cmd_t  cmd_o,
  output logic              busy
);

  import srg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_FILL,
    ST_MIX,
    ST_MIX_END,
    ST_DRAW_RD,
    ST_DRAW_WR
  } state_e;

  state_e st_q;
  logic   busy_q;
  logic   seeded_q;
  logic   did_q;
  logic   accept;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      busy_q   <= 1'b0;
      seeded_q <= 1'b0;
      did_q    <= 1'b0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (accept) begin
            busy_q <= 1'b1;
            if (seed_neg_i || !seeded_q) begin
              did_q <= 1'b1;
              st_q  <= ST_CALC;
            end else begin
              did_q <= 1'b0;
              st_q  <= ST_DRAW_RD;
            end
          end
        end
        ST_CALC: begin
          seeded_q <= 1'b1;
          st_q     <= ST_FILL;
        end
        ST_FILL: begin
          if (stat_i.fill_last) begin
            st_q <= ST_MIX;
          end
        end
        ST_MIX: begin
          if (stat_i.mix_last) begin
            st_q <= ST_MIX_END;
          end
        end
        ST_MIX_END: begin
          st_q <= ST_DRAW_RD;
        end
        ST_DRAW_RD: begin
          st_q <= ST_DRAW_WR;
        end
        ST_DRAW_WR: begin
          busy_q <= 1'b0;
          st_q   <= ST_IDLE;
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.calc       = (st_q == ST_CALC);
    cmd_o.fill       = (st_q == ST_FILL);
    cmd_o.mix        = (st_q == ST_MIX);
    cmd_o.draw_rd    = (st_q == ST_DRAW_RD);
    cmd_o.draw_wr    = (st_q == ST_DRAW_WR);
    cmd_o.did_reseed = did_q;
  end

  // An accepted request always holds the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_q)
    else $error("busy not raised after an accepted request");

  // The write-back step always ends the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (st_q == ST_DRAW_WR) |=> (!busy_q && st_q == ST_IDLE))
    else $error("request did not complete after write-back");

  // Once seeded, the table stays seeded until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(seeded_q))
    else $error("seeded flag cleared without reset");

  // Seeding steps only run for a request that asked for a reseed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (st_q == ST_FILL || st_q == ST_MIX) |-> did_q)
    else $error("table rebuilt for a request that needed no reseed");

endmodule

// ===== design/srg_datapath.sv =====
// Datapath of the subtractive random generator: lag table, counters, cursors, result.
// Depends on srg_pkg and instantiates srg_ram.
module srg_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  srg_pkg::srg_cmd_t                  cmd_i,
  input  logic signed [srg_pkg::SeedW-1:0]   seed_i,
  output srg_pkg::srg_stat_t                 stat_o,
  output logic        [srg_pkg::ValW-1:0]    value_o,
  output logic                               reseeded_o,
  output logic                               done_o
);

  import srg_pkg::*;

  // Seeding registers.
  logic [SeedW-1:0] mag_q;
  logic [ValW-1:0]  mj_q, mk_q;
  logic [IdxW-1:0]  pos_q;
  logic             fill_first_q;

  // Mixing pass counters and the pending write of the previous read step.
  logic [IdxW-1:0]  mix_idx_q;
  logic [PassW-1:0] pass_q;
  logic             mix_wr_q;
  logic [IdxW-1:0]  mix_wa_q;

  // Draw cursors, holding table positions 0..55.
  logic [IdxW-1:0]  near_q, far_q;
  logic [IdxW-1:0]  near_nx, far_nx;

  // Result register.
  logic [ValW-1:0]  value_q;
  logic             reseeded_q;
  logic             done_q;

  // Table port signals.
  logic             we;
  logic [IdxW-1:0]  wa, ra_a, ra_b, partner;
  logic [ValW-1:0]  wd, rd_a, rd_b, diff;
  logic [IdxW:0]    pos_sum, partner_sum;

  // Residue of the seed against the base, brought into [0, 10^9).
  logic [33:0]      d0, d1, d2;
  logic [ValW-1:0]  m_val;

  assign d0 = {4'b0000, SeedBase} - {2'b00, mag_q};
  assign d1 = d0 + {4'b0000, Mod};
  assign d2 = d0 + {3'b000, Mod, 1'b0};

  always_comb begin
    priority if (!d0[33]) begin
      m_val = d0[ValW-1:0];
    end else if (!d1[33]) begin
      m_val = d1[ValW-1:0];
    end else begin
      m_val = d2[ValW-1:0];
    end
  end

  assign pos_sum     = {1'b0, pos_q} + {1'b0, FillStep};
  assign partner_sum = {1'b0, mix_idx_q} + {1'b0, MixOffset};
  assign partner     = (partner_sum >= {1'b0, TblLenIdx}) ?
                       IdxW'(partner_sum - {1'b0, TblLenIdx}) : partner_sum[IdxW-1:0];

  assign near_nx = (near_q >= TblLenIdx) ? IdxW'(1) : near_q + IdxW'(1);
  assign far_nx  = (far_q >= TblLenIdx) ? IdxW'(1) : far_q + IdxW'(1);

  assign diff = sub_mod(rd_a, rd_b);

  always_comb begin
    if (cmd_i.mix) begin
      ra_a = mix_idx_q;
      ra_b = partner;
    end else begin
      ra_a = near_nx - IdxW'(1);
      ra_b = far_nx - IdxW'(1);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = diff;
    priority if (cmd_i.fill) begin
      we = 1'b1;
      if (fill_first_q) begin
        wa = LastIdx;
        wd = mj_q;
      end else begin
        wa = pos_q - IdxW'(1);
        wd = mk_q;
      end
    end else if (mix_wr_q) begin
      we = 1'b1;
      wa = mix_wa_q;
    end else if (cmd_i.draw_wr) begin
      we = 1'b1;
      wa = near_q - IdxW'(1);
    end else begin
      we = 1'b0;
    end
  end

  srg_ram #(
    .Width (ValW),
    .Depth (TblLen),
    .AddrW (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .wa_i   (wa),
    .wd_i   (wd),
    .ra_a_i (ra_a),
    .ra_b_i (ra_b),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // Payload registers of the seeding chain, the pending mixing write address and the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= seed_i[SeedW-1] ? (~seed_i + SeedW'(1)) : seed_i;
    end
    if (cmd_i.calc) begin
      mj_q  <= m_val;
      mk_q  <= ValW'(1);
      pos_q <= '0;
    end else if (cmd_i.fill) begin
      if (fill_first_q) begin
        pos_q <= FillStep;
      end else begin
        mk_q  <= sub_mod(mj_q, mk_q);
        mj_q  <= mk_q;
        pos_q <= (pos_sum >= {1'b0, TblLenIdx}) ?
                 IdxW'(pos_sum - {1'b0, TblLenIdx}) : pos_sum[IdxW-1:0];
      end
    end
    mix_wa_q <= mix_idx_q;
    if (cmd_i.draw_wr) begin
      value_q    <= diff;
      reseeded_q <= cmd_i.did_reseed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_first_q <= 1'b0;
      mix_idx_q    <= '0;
      pass_q       <= '0;
      mix_wr_q     <= 1'b0;
      near_q       <= '0;
      far_q        <= FarStart;
      done_q       <= 1'b0;
    end else begin
      mix_wr_q <= cmd_i.mix;
      done_q   <= cmd_i.draw_wr;
      if (cmd_i.calc) begin
        fill_first_q <= 1'b1;
        mix_idx_q    <= '0;
        pass_q       <= '0;
        near_q       <= '0;
        far_q        <= FarStart;
      end else begin
        if (cmd_i.fill) begin
          fill_first_q <= 1'b0;
        end
        if (cmd_i.mix) begin
          if (mix_idx_q == LastIdx) begin
            mix_idx_q <= '0;
            pass_q    <= pass_q + PassW'(1);
          end else begin
            mix_idx_q <= mix_idx_q + IdxW'(1);
          end
        end
        if (cmd_i.draw_rd) begin
          near_q <= near_nx;
          far_q  <= far_nx;
        end
      end
    end
  end

  assign stat_o.fill_last = !fill_first_q && (pos_q == FillLastPos);
  assign stat_o.mix_last  = (pass_q == LastPass) && (mix_idx_q == LastIdx);

  assign value_o    = value_q;
  assign reseeded_o = reseeded_q;
  assign done_o     = done_q;

  // The mixing pipeline relies on a step never reading the entry that the
  // previous step writes in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (mix_wr_q && cmd_i.mix) |-> (mix_wa_q != ra_a && mix_wa_q != ra_b))
    else $error("mixing read collides with the pending write");

  // Cursors always name a valid table position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (near_q <= TblLenIdx) && (far_q <= TblLenIdx))
    else $error("cursor out of range");

  // A presented result is always a residue modulo 10^9.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (value_q < Mod))
    else $error("result not reduced modulo 10^9");

endmodule

// ===== design/subtractive_random_generator_unit.sv =====
// Top level of the subtractive lagged-Fibonacci random generator.
// Depends on srg_pkg and instantiates srg_ctrl and srg_datapath.
//
// Usage: a request is taken at a rising clock edge where start is high and
// busy is low; seed_i is sampled at that edge. Each request gives exactly one
// result: value_o (an integer in 0 to 999999999, the deviate being value_o
// times 1e-9) and reseeded_o, shown for a single cycle while done_o is high.
// The receiver cannot stall; the result is taken in the cycle it is shown.
//
// A request whose seed is negative, or the first request after reset,
// rebuilds the 55-entry lag table from the seed magnitude first. Otherwise a
// draw reads the two entries under the advanced cursors (the table RAM read
// is registered), writes their difference modulo 10^9 back, and shows it
// from the result register after the read and write-back states; busy is
// high through both, so no new request is taken before the write-back.
// A reseed first reduces the seed, makes 55 fill writes, and runs 220
// mixing steps at one per cycle plus one to drain the last write-back.
//
// Reset clears the cursors to 0 and 31 and marks the table unseeded; the
// table contents themselves are not cleared, as the first request reseeds.
module subtractive_random_generator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [srg_pkg::SeedW-1:0] seed_i,
  output logic        [srg_pkg::ValW-1:0]  value_o,
  output logic                             reseeded_o,
  output logic                             done_o
);

  import srg_pkg::*;

  srg_cmd_t  cmd;
  srg_stat_t stat;

  // The controller sequences seeding and draws; it sees only the seed sign.
  srg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .seed_neg_i (seed_i[SeedW-1]),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  // The datapath holds the table, the cursors and the result register.
  srg_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .seed_i     (seed_i),
    .stat_o     (stat),
    .value_o    (value_o),
    .reseeded_o (reseeded_o),
    .done_o     (done_o)
  );

endmodule
